### rtl/balu_pkg.sv
// Shared types and operation codes for the byte ALU with flags.
package balu_pkg;

    localparam int OP_W   = 5;
    localparam int DATA_W = 8;

    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
    localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
    localparam logic [OP_W-1:0] OP_CMP   = 5'd4;
    localparam logic [OP_W-1:0] OP_OR    = 5'd5;
    localparam logic [OP_W-1:0] OP_AND   = 5'd6;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd7;
    localparam logic [OP_W-1:0] OP_BIT   = 5'd8;
    localparam logic [OP_W-1:0] OP_RSBC  = 5'd9;
    localparam logic [OP_W-1:0] OP_RCMP  = 5'd10;
    localparam logic [OP_W-1:0] OP_INC   = 5'd11;
    localparam logic [OP_W-1:0] OP_DEC   = 5'd12;
    localparam logic [OP_W-1:0] OP_RRC   = 5'd13;
    localparam logic [OP_W-1:0] OP_RLC   = 5'd14;
    localparam logic [OP_W-1:0] OP_SAL   = 5'd15;
    localparam logic [OP_W-1:0] OP_SAR   = 5'd16;
    localparam logic [OP_W-1:0] OP_LSR   = 5'd17;
    localparam logic [OP_W-1:0] OP_COM   = 5'd18;
    localparam logic [OP_W-1:0] OP_ROL   = 5'd19;
    localparam logic [OP_W-1:0] OP_RR    = 5'd20;
    localparam logic [OP_W-1:0] OP_INCZ  = 5'd21;
    localparam logic [OP_W-1:0] OP_DECZ  = 5'd22;
    localparam logic [OP_W-1:0] OP_PASSN = 5'd23;
    localparam logic [OP_W-1:0] OP_PASS  = 5'd24;
    localparam logic [OP_W-1:0] OP_ADDNC = 5'd25;
    localparam logic [OP_W-1:0] OP_SUBNC = 5'd26;

    typedef logic [OP_W-1:0]   opcode_t;
    typedef logic [DATA_W-1:0] byte_t;

    typedef struct packed {
        logic c;
        logic z;
        logic n;
    } flags_t;

    typedef struct packed {
        byte_t  value;
        logic   wb;
        flags_t flags;
    } alu_res_t;

endpackage

### rtl/balu_ifs.sv
// Request and result channel interfaces of the byte ALU.
interface balu_req_if
    import balu_pkg::*;
();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    byte_t   dest_value;
    byte_t   source_value;

    modport source (output valid, output opcode, output dest_value, output source_value,
                    input ready);
    modport sink (input valid, input opcode, input dest_value, input source_value,
                  output ready);
endinterface

interface balu_res_if
    import balu_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t result_value;
    logic  write_back;
    logic  carry_out;
    logic  zero_out;
    logic  negative_out;

    modport source (output valid, output result_value, output write_back, output carry_out,
                    output zero_out, output negative_out, input ready);
    modport sink (input valid, input result_value, input write_back, input carry_out,
                  input zero_out, input negative_out, output ready);
endinterface

### rtl/balu_core.sv
// Combinational ALU datapath: computes the result byte and the next flags.
module balu_core
    import balu_pkg::*;
(
    input  opcode_t  op,
    input  byte_t    dest,
    input  byte_t    src,
    input  flags_t   flags_in,
    output alu_res_t result
);

    logic [DATA_W:0] res9;
    logic            upd_c;
    logic            upd_z;
    logic            upd_n;
    logic            c_val;
    logic            wb;
    logic [DATA_W:0] cin9;
    byte_t           r;

    assign cin9 = {{DATA_W{1'b0}}, flags_in.c};

    always_comb
    begin
        res9  = '0;
        upd_c = 1'b0;
        upd_z = 1'b0;
        upd_n = 1'b0;
        c_val = 1'b0;
        wb    = 1'b1;
        case (op)
            OP_ADD:
            begin
                res9 = {1'b0, dest} + {1'b0, src};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = res9[DATA_W];
            end
            OP_ADC:
            begin
                res9 = {1'b0, dest} + {1'b0, src} + cin9;
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = res9[DATA_W];
            end
            OP_SUB, OP_CMP:
            begin
                res9 = {1'b0, dest} - {1'b0, src};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = res9[DATA_W];
                wb = (op == OP_SUB);
            end
            OP_SBC:
            begin
                res9 = {1'b0, dest} - {1'b0, src} - cin9;
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = res9[DATA_W];
            end
            OP_RSBC:
            begin
                res9 = {1'b0, src} - {1'b0, dest} - cin9;
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = res9[DATA_W];
            end
            OP_RCMP:
            begin
                res9 = {1'b0, src} - {1'b0, dest};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = res9[DATA_W];
                wb = 1'b0;
            end
            OP_OR:
            begin
                res9 = {1'b0, dest | src};
                {upd_z, upd_n} = 2'b11;
            end
            OP_AND, OP_BIT:
            begin
                res9 = {1'b0, dest & src};
                {upd_z, upd_n} = 2'b11;
                wb = (op == OP_AND);
            end
            OP_XOR:
            begin
                res9 = {1'b0, dest ^ src};
                {upd_z, upd_n} = 2'b11;
            end
            OP_INC:
            begin
                res9 = {1'b0, dest} + 9'd1;
                {upd_z, upd_n} = 2'b11;
            end
            OP_DEC:
            begin
                res9 = {1'b0, dest} - 9'd1;
                {upd_z, upd_n} = 2'b11;
            end
            OP_RRC:
            begin
                res9 = {1'b0, flags_in.c, dest[DATA_W-1:1]};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = dest[0];
            end
            OP_RLC:
            begin
                res9 = {1'b0, dest[DATA_W-2:0], flags_in.c};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = dest[DATA_W-1];
            end
            OP_SAL:
            begin
                res9 = {1'b0, dest[DATA_W-2:0], 1'b0};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = dest[DATA_W-1];
            end
            OP_SAR:
            begin
                res9 = {1'b0, dest[DATA_W-1], dest[DATA_W-1:1]};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = dest[0];
            end
            OP_LSR:
            begin
                res9 = {2'b00, dest[DATA_W-1:1]};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = dest[0];
            end
            OP_COM:
            begin
                res9 = {1'b0, ~dest};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = 1'b1;
            end
            OP_ROL:
            begin
                res9 = {1'b0, dest[DATA_W-2:0], dest[DATA_W-1]};
                {upd_z, upd_n} = 2'b11;
            end
            OP_RR:
            begin
                res9 = {1'b0, dest[0], dest[DATA_W-1:1]};
                {upd_z, upd_n} = 2'b11;
            end
            OP_INCZ:
            begin
                res9 = {1'b0, dest} + 9'd1;
                upd_z = 1'b1;
            end
            OP_DECZ:
            begin
                res9 = {1'b0, dest} - 9'd1;
                upd_z = 1'b1;
            end
            OP_PASSN:
            begin
                res9 = {1'b0, dest};
                upd_n = 1'b1;
            end
            OP_PASS:
            begin
                res9 = {1'b0, dest};
            end
            OP_ADDNC:
            begin
                res9 = {1'b0, dest} + {1'b0, src};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = 1'b0;
            end
            OP_SUBNC:
            begin
                res9 = {1'b0, dest} - {1'b0, src};
                {upd_c, upd_z, upd_n} = 3'b111;
                c_val = 1'b0;
            end
            default:
            begin
                res9 = '0;
                wb   = 1'b0;
            end
        endcase
    end

    assign r = res9[DATA_W-1:0];

    assign result.value   = r;
    assign result.wb      = wb;
    assign result.flags.c = upd_c ? c_val : flags_in.c;
    assign result.flags.z = upd_z ? (r == '0) : flags_in.z;
    assign result.flags.n = upd_n ? r[DATA_W-1] : flags_in.n;

endmodule

### rtl/byte_alu_with_flags.sv
// Top level of the 8-bit ALU with carry, zero and negative flags.
// The block takes one request per cycle while the result channel is not stalled and
// returns one result per request, in order. A request is captured in an input
// register, passes through the ALU and lands in the result register, from which it is
// offered; a stalled result channel keeps it there, and a full input register then
// stops requests. The flags are updated as each request leaves the input register;
// the flag register feeds the ALU directly, so a dependent request can follow in the
// very next cycle.
module byte_alu_with_flags
    import balu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    balu_req_if.sink   request,
    balu_res_if.source result
);

    logic     s1_valid_reg;
    opcode_t  s1_op_reg;
    byte_t    s1_dest_reg;
    byte_t    s1_src_reg;
    logic     s2_valid_reg;
    alu_res_t s2_res_reg;
    flags_t   flags_reg;
    flags_t   flags_next;
    alu_res_t alu_res;
    logic     advance;
    logic     take;

    assign advance       = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign take          = request.valid && request.ready;
    assign request.ready = !s1_valid_reg || advance;

    balu_core u_core (
        .op       (s1_op_reg),
        .dest     (s1_dest_reg),
        .src      (s1_src_reg),
        .flags_in (flags_reg),
        .result   (alu_res)
    );

    assign flags_next = advance ? alu_res.flags : flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            if (request.ready)
            begin
                s1_valid_reg <= request.valid;
            end
            if (advance)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                s2_valid_reg <= 1'b0;
            end
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_op_reg   <= request.opcode;
            s1_dest_reg <= request.dest_value;
            s1_src_reg  <= request.source_value;
        end
        if (advance)
        begin
            s2_res_reg <= alu_res;
        end
    end

    assign result.valid        = s2_valid_reg;
    assign result.result_value = s2_res_reg.value;
    assign result.write_back   = s2_res_reg.wb;
    assign result.carry_out    = s2_res_reg.flags.c;
    assign result.zero_out     = s2_res_reg.flags.z;
    assign result.negative_out = s2_res_reg.flags.n;

`ifndef NO_ASSERTIONS
    a_flags_track_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (flags_reg == s2_res_reg.flags))
        else $error("Flag state differs from the flags of the last result.");

    a_pass_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == OP_PASS) |=> $stable(flags_reg))
        else $error("Pass operation changed the flags.");

    a_com_sets_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == OP_COM) |=> flags_reg.c)
        else $error("Complement did not set carry.");

    a_full_take_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s1_valid_reg) |-> advance)
        else $error("Request accepted while the input register could not drain.");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the byte ALU: predicts every result and flag and compares in order.
module testbench;
    import balu_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PRINT_LIMIT    = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    balu_req_if req_ch ();
    balu_res_if res_ch ();

    byte_alu_with_flags dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    flags_t   alu_flags = '0;
    alu_res_t expected_results[$];
    int       mismatch_count = 0;
    int       gap_pct = 0;
    int       stall_pct = 0;
    int       holdoff_len = 0;
    int       idle_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    function automatic alu_res_t predict_alu(opcode_t op, byte_t d, byte_t s);
        logic [15:0] word;
        logic        arith;
        logic        set_zn;
        logic        wb;
        byte_t       r;
        flags_t      nf;
        alu_res_t    res;
        nf = alu_flags;
        word = '0;
        arith = 1'b0;
        set_zn = 1'b0;
        wb = 1'b1;
        r = '0;
        case (op)
            OP_ADD:   begin word = {8'h00, d} + {8'h00, s}; arith = 1'b1; end
            OP_ADC:   begin word = {8'h00, d} + {8'h00, s} + 16'(nf.c); arith = 1'b1; end
            OP_SUB:   begin word = {8'h00, d} - {8'h00, s}; arith = 1'b1; end
            OP_SBC:   begin word = {8'h00, d} - {8'h00, s} - 16'(nf.c); arith = 1'b1; end
            OP_CMP:   begin word = {8'h00, d} - {8'h00, s}; arith = 1'b1; wb = 1'b0; end
            OP_RSBC:  begin word = {8'h00, s} - {8'h00, d} - 16'(nf.c); arith = 1'b1; end
            OP_RCMP:  begin word = {8'h00, s} - {8'h00, d}; arith = 1'b1; wb = 1'b0; end
            OP_COM:   begin word = {8'hFF, ~d}; arith = 1'b1; end
            OP_ADDNC: begin word = {8'h00, 8'(d + s)}; arith = 1'b1; end
            OP_SUBNC: begin word = {8'h00, 8'(d - s)}; arith = 1'b1; end
            OP_OR:    begin r = d | s; set_zn = 1'b1; end
            OP_AND:   begin r = d & s; set_zn = 1'b1; end
            OP_XOR:   begin r = d ^ s; set_zn = 1'b1; end
            OP_BIT:   begin r = d & s; set_zn = 1'b1; wb = 1'b0; end
            OP_INC:   begin r = d + 8'd1; set_zn = 1'b1; end
            OP_DEC:   begin r = d - 8'd1; set_zn = 1'b1; end
            OP_ROL:   begin r = {d[6:0], d[7]}; set_zn = 1'b1; end
            OP_RR:    begin r = {d[0], d[7:1]}; set_zn = 1'b1; end
            OP_RRC:   begin r = {nf.c, d[7:1]}; nf.c = d[0]; set_zn = 1'b1; end
            OP_RLC:   begin r = {d[6:0], nf.c}; nf.c = d[7]; set_zn = 1'b1; end
            OP_SAL:   begin r = {d[6:0], 1'b0}; nf.c = d[7]; set_zn = 1'b1; end
            OP_SAR:   begin r = {d[7], d[7:1]}; nf.c = d[0]; set_zn = 1'b1; end
            OP_LSR:   begin r = {1'b0, d[7:1]}; nf.c = d[0]; set_zn = 1'b1; end
            OP_INCZ:  begin r = d + 8'd1; nf.z = (r == 8'h00); end
            OP_DECZ:  begin r = d - 8'd1; nf.z = (r == 8'h00); end
            OP_PASSN: begin r = d; nf.n = d[7]; end
            OP_PASS:  r = d;
            default:  wb = 1'b0;
        endcase
        if (arith)
        begin
            r = word[7:0];
            nf.c = (word >= 16'h0100);
            set_zn = 1'b1;
        end
        if (set_zn)
        begin
            nf.z = (r == 8'h00);
            nf.n = r[7];
        end
        alu_flags = nf;
        res.value = r;
        res.wb = wb;
        res.flags = nf;
        return res;
    endfunction

    function automatic byte_t pick_operand();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return ($urandom_range(0, 1) != 0) ? 8'h80 : 8'h7F;
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic opcode_t pick_opcode();
        if ($urandom_range(0, 19) == 0)
            return opcode_t'($urandom_range(OP_SUBNC + 1, (1 << OP_W) - 1));
        return opcode_t'($urandom_range(OP_ADD, OP_SUBNC));
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    // The request stays offered until accepted; valid is only lowered for a gap.
    task automatic send_request(opcode_t op, byte_t d, byte_t s);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.dest_value <= d;
        req_ch.source_value <= s;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        expected_results.push_back(predict_alu(op, d, s));
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic test_each_operation();
        byte_t   corner[5];
        opcode_t named_ops[27];
        corner = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
        named_ops = '{OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CMP, OP_OR, OP_AND, OP_XOR, OP_BIT,
                      OP_RSBC, OP_RCMP, OP_INC, OP_DEC, OP_RRC, OP_RLC, OP_SAL, OP_SAR,
                      OP_LSR, OP_COM, OP_ROL, OP_RR, OP_INCZ, OP_DECZ, OP_PASSN, OP_PASS,
                      OP_ADDNC, OP_SUBNC};
        gap_pct = 20;
        stall_pct = 5;
        foreach (named_ops[i])
            send_request(named_ops[i], corner[i % 5], corner[(i + 2) % 5]);
        for (int k = OP_SUBNC + 1; k < (1 << OP_W); k++)
            send_request(opcode_t'(k), corner[k % 5], corner[(k + 1) % 5]);
    endtask

    task automatic test_flag_corners();
        gap_pct = 0;
        stall_pct = 0;
        send_request(OP_ADD, 8'hFF, 8'h01);
        send_request(OP_ADC, 8'hFF, 8'h00);
        send_request(OP_SBC, 8'h00, 8'h00);
        send_request(OP_RSBC, 8'h00, 8'h00);
        send_request(OP_RRC, 8'h01, 8'h00);
        send_request(OP_INCZ, 8'hFF, 8'h00);
        send_request(OP_PASS, 8'h00, 8'h00);
        send_request(OP_SUBNC, 8'h00, 8'h01);
        send_request(OP_CMP, 8'h10, 8'h10);
        send_request(opcode_t'(OP_SUBNC + 1), 8'hFF, 8'hFF);
    endtask

    task automatic test_random_mix();
        int pct_choice[3];
        pct_choice = '{0, 5, 20};
        for (int chunk = 0; chunk < 11; chunk++)
        begin
            gap_pct = pct_choice[$urandom_range(0, 2)] * 2;
            stall_pct = pct_choice[$urandom_range(0, 2)];
            repeat (50) send_request(pick_opcode(), pick_operand(), pick_operand());
        end
    endtask

    // The result side holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        gap_pct = 0;
        stall_pct = 0;
        holdoff_len = 80;
        repeat (24) send_request(pick_opcode(), pick_operand(), pick_operand());
        drain_results();
    endtask

    task automatic test_steady_stream();
        gap_pct = 0;
        stall_pct = 0;
        repeat (50) send_request(pick_opcode(), pick_operand(), pick_operand());
    endtask

    initial
    begin : receiver
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holdoff_len != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (holdoff_len) @(posedge clk);
                holdoff_len = 0;
                res_ch.ready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        alu_res_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0h arrived with none outstanding",
                                          res_ch.result_value));
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_value", res_ch.result_value, want.value);
                check_field("write_back", 8'(res_ch.write_back), 8'(want.wb));
                check_field("carry_out", 8'(res_ch.carry_out), 8'(want.flags.c));
                check_field("zero_out", 8'(res_ch.zero_out), 8'(want.flags.z));
                check_field("negative_out", 8'(res_ch.negative_out), 8'(want.flags.n));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.opcode <= OP_ADD;
        req_ch.dest_value <= '0;
        req_ch.source_value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_each_operation();
        test_flag_corners();
        test_random_mix();
        test_backpressure();
        test_steady_stream();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### byte_alu_with_flags.f
rtl/balu_pkg.sv
rtl/balu_ifs.sv
rtl/balu_core.sv
rtl/byte_alu_with_flags.sv
sim/testbench.sv
